// ----- rtl/core/sadc_pkg.sv -----
// shared types, constants and control structs of the sar adc channel converter
package sadc_pkg;

	localparam int unsigned CODE_W     = 16;
	localparam int unsigned RES_W      = 8;
	localparam int unsigned CMD_W      = 2;
	localparam int unsigned CHAN_W     = 3;
	localparam int unsigned PHASE_W    = 3;
	localparam int unsigned BITCNT_W   = 4;
	localparam int unsigned CFG_IDX_W  = 1;
	localparam int unsigned CFG_DATA_W = 16;
	localparam int unsigned DIV_STEP_W = 4;

	// command codes of an input word
	typedef logic [CMD_W-1:0] cmd_t;
	localparam cmd_t CMD_TICK  = 2'd0;
	localparam cmd_t CMD_ALE   = 2'd1;
	localparam cmd_t CMD_START = 2'd2;
	localparam cmd_t CMD_READ  = 2'd3;

	// configuration register indexes
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	localparam cfg_idx_t REG_REF_HIGH = 1'd0;
	localparam cfg_idx_t REG_REF_LOW  = 1'd1;

	localparam logic [CODE_W-1:0] REF_HIGH_RST = 16'hFFFF;
	localparam logic [CODE_W-1:0] REF_LOW_RST  = 16'h0000;

	// converter cycle positions
	localparam logic [PHASE_W-1:0] PHASE_SAMPLE = 3'd7;
	localparam logic [PHASE_W-1:0] PHASE_EOC    = 3'd0;

	// bit count just before the sampling step, and its saturation value
	localparam logic [BITCNT_W-1:0] BIT_LAST = 4'd7;
	localparam logic [BITCNT_W-1:0] BIT_SAT  = 4'd9;

	// divider sequence: one setup step, then one quotient bit per step
	localparam logic [DIV_STEP_W-1:0] DIV_LAST = 4'd8;

	typedef struct packed {
		logic accept;
		logic prep;
		logic iter;
		logic finish;
	} sadc_ctl_t;

	typedef struct packed {
		logic needs_div;
	} sadc_sts_t;

endpackage

// ----- rtl/core/sadc_item_if.sv -----
// input word channel and result word channel of the converter
interface sadc_item_if;
	import sadc_pkg::*;

	logic              valid;
	logic              ready;
	cmd_t              cmd;
	logic              pin_level;
	logic [CHAN_W-1:0] channel_addr;
	logic [CODE_W-1:0] sample_value;

	modport source (output valid, cmd, pin_level, channel_addr, sample_value, input ready);
	modport sink (input valid, cmd, pin_level, channel_addr, sample_value, output ready);
endinterface

interface sadc_result_if;
	import sadc_pkg::*;

	logic             valid;
	logic             ready;
	logic [RES_W-1:0] data_out;
	logic             eoc_level;
	logic             eoc_changed;

	modport source (output valid, data_out, eoc_level, eoc_changed, input ready);
	modport sink (input valid, data_out, eoc_level, eoc_changed, output ready);
endinterface

// ----- rtl/core/sar_adc_channel_converter.sv -----
// top level of the eight-channel eight-bit sar adc channel converter
// Each input word (converter tick, ALE write, START write or data read) yields
// one result word with the result register, the EOC pin level and an EOC change
// flag. The result of a word is valid in the cycle after the word is taken,
// except the tick that completes a conversion: it scales the sample against the
// reference registers with a restoring divider that makes one quotient bit a
// cycle; its result appears after one setup step and eight divider steps, the
// last of which loads the result register. The next input word is taken while
// a result waits only in the cycle the result is taken. The user must write
// ref_high and ref_low through the configuration port only while no word is in
// work; the block itself does not enforce this.
module sar_adc_channel_converter (
	input  logic                            clk,
	input  logic                            arst_n,
	sadc_item_if.sink                       item,
	sadc_result_if.source                   result,
	input  logic                            cfg_we,
	input  sadc_pkg::cfg_idx_t              cfg_index,
	input  logic [sadc_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import sadc_pkg::*;

	sadc_ctl_t ctl;
	sadc_sts_t sts;

	// handshake and sequencing
	sadc_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item.valid),
		.item_ready   (item.ready),
		.result_valid (result.valid),
		.result_ready (result.ready),
		.ctl          (ctl),
		.sts          (sts)
	);

	// converter state and scaling
	sadc_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.sts          (sts),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.cmd          (item.cmd),
		.pin_level    (item.pin_level),
		.sample_value (item.sample_value),
		.data_out     (result.data_out),
		.eoc_level    (result.eoc_level),
		.eoc_changed  (result.eoc_changed)
	);

endmodule

// ----- rtl/core/sadc_ctrl.sv -----
// controller: handshake, result valid and divider step sequencing
module sadc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_ready,
	output logic                result_valid,
	input  logic                result_ready,
	output sadc_pkg::sadc_ctl_t ctl,
	input  sadc_pkg::sadc_sts_t sts
);
	import sadc_pkg::*;

	typedef enum logic {
		ST_IDLE,
		ST_DIV
	} state_t;

	state_t                state_q;
	logic [DIV_STEP_W-1:0] step_q;
	logic                  out_valid_q;
	logic                  accept;

	// take a word when idle and the result slot is free or draining
	assign item_ready   = (state_q == ST_IDLE) && (!out_valid_q || result_ready);
	assign accept       = item_valid && item_ready;
	assign result_valid = out_valid_q;

	// commands to the datapath
	always_comb begin
		ctl.accept = accept;
		ctl.prep   = (state_q == ST_DIV) && (step_q == '0);
		ctl.iter   = (state_q == ST_DIV) && (step_q != '0);
		ctl.finish = (state_q == ST_DIV) && (step_q == DIV_LAST);
	end

	// state, step counter and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (sts.needs_div) begin
							state_q     <= ST_DIV;
							step_q      <= '0;
							out_valid_q <= 1'b0;
						end else begin
							out_valid_q <= 1'b1;
						end
					end else if (result_ready) begin
						out_valid_q <= 1'b0;
					end
				end
				ST_DIV: begin
					step_q <= step_q + 1'b1;
					if (step_q == DIV_LAST) begin
						state_q     <= ST_IDLE;
						out_valid_q <= 1'b1;
					end
				end
			endcase
		end
	end

endmodule

// ----- rtl/core/sadc_dp.sv -----
// datapath: converter state, reference registers and the scaling divider
module sadc_dp (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  sadc_pkg::sadc_ctl_t                       ctl,
	output sadc_pkg::sadc_sts_t                       sts,
	input  logic                                      cfg_we,
	input  sadc_pkg::cfg_idx_t                        cfg_index,
	input  logic [sadc_pkg::CFG_DATA_W-1:0]           cfg_wdata,
	input  sadc_pkg::cmd_t                            cmd,
	input  logic                                      pin_level,
	input  logic [sadc_pkg::CODE_W-1:0]               sample_value,
	output logic [sadc_pkg::RES_W-1:0]                data_out,
	output logic                                      eoc_level,
	output logic                                      eoc_changed
);
	import sadc_pkg::*;

	localparam int unsigned NUM_W = CODE_W + RES_W;

	logic [CODE_W-1:0]   ref_high_q;
	logic [CODE_W-1:0]   ref_low_q;
	logic                start_prev_q;
	logic                eoc_pin_q;
	logic                eoc_pending_q;
	logic                eoc_changed_q;
	logic [RES_W-1:0]    result_q;
	logic [PHASE_W-1:0]  phase_q;
	logic [BITCNT_W-1:0] bit_count_q;

	logic [CODE_W-1:0]   diff_q;
	logic [CODE_W-1:0]   den_q;
	logic [CODE_W-1:0]   rem_q;
	logic [RES_W-1:0]    low_q;
	logic [RES_W-1:0]    quo_q;
	logic                zero_q;
	logic                ovf_q;

	logic                is_tick;
	logic                conv_slot;
	logic                eoc_update;
	logic [NUM_W-1:0]    num;
	logic [CODE_W:0]     trial;
	logic [CODE_W:0]     trial_sub;
	logic                trial_ge;
	logic [CODE_W-1:0]   rem_next;
	logic [RES_W-1:0]    quo_next;
	logic [RES_W-1:0]    final_q;

	// decode of the current word against the converter state
	assign is_tick       = (cmd == CMD_TICK);
	assign conv_slot     = is_tick && !start_prev_q && (phase_q == PHASE_SAMPLE);
	assign sts.needs_div = conv_slot && (bit_count_q == BIT_LAST);
	assign eoc_update    = is_tick && (phase_q == PHASE_EOC) && (eoc_pending_q != eoc_pin_q);

	// numerator 255 * diff as 256 * diff - diff
	assign num = {diff_q, {RES_W{1'b0}}} - {{RES_W{1'b0}}, diff_q};

	// one restoring division step
	assign trial     = {rem_q, low_q[RES_W-1]};
	assign trial_ge  = (trial >= {1'b0, den_q});
	assign trial_sub = trial - {1'b0, den_q};
	assign rem_next  = trial_ge ? trial_sub[CODE_W-1:0] : trial[CODE_W-1:0];
	assign quo_next  = {quo_q[RES_W-2:0], trial_ge};

	// saturate below and above the reference range
	assign final_q = zero_q ? '0 : (ovf_q ? '1 : quo_next);

	// architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_high_q    <= REF_HIGH_RST;
			ref_low_q     <= REF_LOW_RST;
			start_prev_q  <= 1'b0;
			eoc_pin_q     <= 1'b1;
			eoc_pending_q <= 1'b0;
			eoc_changed_q <= 1'b0;
			result_q      <= '0;
			phase_q       <= '0;
			bit_count_q   <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_REF_HIGH: ref_high_q <= cfg_wdata;
					REG_REF_LOW:  ref_low_q  <= cfg_wdata;
				endcase
			end
			if (ctl.accept) begin
				eoc_changed_q <= eoc_update;
				unique case (cmd) inside
					CMD_TICK: begin
						if (conv_slot && (bit_count_q != BIT_SAT)) begin
							bit_count_q <= bit_count_q + 1'b1;
						end
						if (sts.needs_div) begin
							eoc_pending_q <= 1'b1;
						end
						if (eoc_update) begin
							eoc_pin_q <= eoc_pending_q;
						end
						phase_q <= phase_q + 1'b1;
					end
					CMD_START: begin
						if (!start_prev_q && pin_level) begin
							result_q    <= '0;
							bit_count_q <= '0;
						end else if (start_prev_q && !pin_level) begin
							eoc_pending_q <= 1'b0;
						end
						start_prev_q <= pin_level;
					end
					// the channel latch has no visible effect: the sample already
					// carries the selected channel
					CMD_ALE, CMD_READ: begin
					end
				endcase
			end
			if (ctl.finish) begin
				result_q <= final_q;
			end
		end
	end

	// divider operands and iteration registers
	always_ff @(posedge clk) begin
		if (ctl.accept) begin
			diff_q <= sample_value - ref_low_q;
			den_q  <= ref_high_q - ref_low_q;
			zero_q <= (ref_high_q <= ref_low_q) || (sample_value <= ref_low_q);
		end
		if (ctl.prep) begin
			rem_q <= num[NUM_W-1:RES_W];
			low_q <= num[RES_W-1:0];
			ovf_q <= (num[NUM_W-1:RES_W] >= den_q);
			quo_q <= '0;
		end else if (ctl.iter) begin
			rem_q <= rem_next;
			low_q <= {low_q[RES_W-2:0], 1'b0};
			quo_q <= quo_next;
		end
	end

	assign data_out    = result_q;
	assign eoc_level   = eoc_pin_q;
	assign eoc_changed = eoc_changed_q;

endmodule

// ----- rtl/core/sadc_checker.sv -----
// port-level checks of the converter, bound to the top level
module sadc_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         item_valid,
	input logic                         item_ready,
	input sadc_pkg::cmd_t               item_cmd,
	input logic                         result_valid,
	input logic                         result_ready,
	input logic [sadc_pkg::RES_W-1:0]   result_data_out,
	input logic                         result_eoc_level,
	input logic                         result_eoc_changed
);
	import sadc_pkg::*;

	logic item_acc;

	assign item_acc = item_valid && item_ready;

	// a stalled result word holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result_data_out)
			&& $stable(result_eoc_level) && $stable(result_eoc_changed))
		else $error("stalled result word changed");

	// no new word is taken while a result is stalled
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |-> !item_ready)
		else $error("input taken while result stalled");

	// pin writes and reads answer in the next cycle and never move the eoc pin
	a_non_tick: assert property (@(posedge clk) disable iff (!arst_n)
		item_acc && (item_cmd != CMD_TICK) |=> result_valid && !result_eoc_changed)
		else $error("non-tick word result late or flagged eoc change");

	// a data read leaves the result and the eoc pin as they were
	a_read_stable: assert property (@(posedge clk) disable iff (!arst_n)
		item_acc && (item_cmd == CMD_READ) |=>
			(result_data_out == $past(result_data_out))
			&& (result_eoc_level == $past(result_eoc_level)))
		else $error("data read changed converter state");

endmodule

bind sar_adc_channel_converter sadc_checker u_sadc_checker (
	.clk                (clk),
	.arst_n             (arst_n),
	.item_valid         (item.valid),
	.item_ready         (item.ready),
	.item_cmd           (item.cmd),
	.result_valid       (result.valid),
	.result_ready       (result.ready),
	.result_data_out    (result.data_out),
	.result_eoc_level   (result.eoc_level),
	.result_eoc_changed (result.eoc_changed)
);
